// File: hw/rtl/mdg_pkg.sv
// Shared types, constants and tables for the double Gaussian Metropolis sampler.
package mdg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int RAND_BITS = 16;
  localparam int POS_W     = 24;
  localparam int DELTA_W   = 23;
  localparam int DENS_W    = 36;
  localparam int REJ_W     = 32;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int QUOT_W    = 5 + FRAC_BITS;
  localparam int DIV_STEPS = QUOT_W;
  localparam int EXP_TERMS = 12;
  localparam int POW_N     = 5;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [REJ_W-1:0] REJ_MAX = '1;
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_DELTA = 2'd1;
  localparam logic [1:0] REG_MU    = 2'd2;
  localparam logic [1:0] REG_SIGMA = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROP_MUL,
    OP_PROP_ADD,
    OP_DEN_MUL,
    OP_DEN_SET,
    OP_DIFF,
    OP_SQ_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EXP_MUL,
    OP_EXP_TAKE,
    OP_H_MUL,
    OP_H_RMUL,
    OP_H_FIX,
    OP_FIN_MUL
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       fin_add;
    logic       psi_mul;
    logic       dn_take;
    logic       acc_mul;
    logic       commit;
    logic [3:0] idx;
    logic       side;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic start;
    logic out_busy;
  } status_t;

  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] m;
    unique case (k)
      4'd1:    m = 32'd4294967295;
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      4'd11:   m = 32'd390451572;
      4'd12:   m = 32'd357913941;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

  function automatic logic [30:0] exp_pow(input logic [2:0] i);
    logic [30:0] v;
    unique case (i)
      3'd0:    v = 31'd395007542;
      3'd1:    v = 31'd145315154;
      3'd2:    v = 31'd19666267;
      3'd3:    v = 31'd360200;
      3'd4:    v = 31'd121;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/mdg_ctrl.sv
// Sequencer that steps the shared datapath through one chain update.
module mdg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mdg_pkg::status_t st,
  output mdg_pkg::cmd_t   cmd
);
  import mdg_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PROP_MUL, S_PROP_ADD, S_DEN_MUL, S_DEN_SET, S_DIFF, S_SQ_MUL,
    S_DIV_INIT, S_DIV_STEP, S_EXP_MUL, S_EXP_TAKE, S_H_MUL, S_H_RMUL, S_H_FIX,
    S_FIN_MUL, S_FIN_ADD, S_PSI_MUL, S_DN, S_ACC_MUL, S_COMMIT
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  logic       side;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.op   = OP_NONE;
    cmd.idx  = cnt[3:0];
    cmd.side = side;
    unique case (state)
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_PROP_MUL: cmd.op = OP_PROP_MUL;
      S_PROP_ADD: cmd.op = OP_PROP_ADD;
      S_DEN_MUL:  cmd.op = OP_DEN_MUL;
      S_DEN_SET:  cmd.op = OP_DEN_SET;
      S_DIFF:     cmd.op = OP_DIFF;
      S_SQ_MUL:   cmd.op = OP_SQ_MUL;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV_STEP: cmd.op = st.zero ? OP_NONE : OP_DIV_STEP;
      S_EXP_MUL:  cmd.op = OP_EXP_MUL;
      S_EXP_TAKE: cmd.op = OP_EXP_TAKE;
      S_H_MUL:    cmd.op = OP_H_MUL;
      S_H_RMUL:   cmd.op = OP_H_RMUL;
      S_H_FIX:    cmd.op = OP_H_FIX;
      S_FIN_MUL:  cmd.op = OP_FIN_MUL;
      S_FIN_ADD:  cmd.fin_add = 1'b1;
      S_PSI_MUL:  cmd.psi_mul = 1'b1;
      S_DN:       cmd.dn_take = 1'b1;
      S_ACC_MUL:  cmd.acc_mul = 1'b1;
      S_COMMIT:   cmd.commit = !st.out_busy;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      side  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:     if (in_valid) state <= S_PROP_MUL;
        S_PROP_MUL: state <= S_PROP_ADD;
        S_PROP_ADD: state <= S_DEN_MUL;
        S_DEN_MUL:  state <= S_DEN_SET;
        S_DEN_SET: begin
          side  <= 1'b0;
          state <= S_DIFF;
        end
        S_DIFF:     state <= S_SQ_MUL;
        S_SQ_MUL:   state <= S_DIV_INIT;
        S_DIV_INIT: begin
          cnt   <= 5'(DIV_STEPS - 1);
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          if (st.zero) begin
            if (side) begin
              state <= S_PSI_MUL;
            end else begin
              side  <= 1'b1;
              state <= S_DIFF;
            end
          end else if (cnt == '0) begin
            state <= S_EXP_MUL;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        S_EXP_MUL:  state <= S_EXP_TAKE;
        S_EXP_TAKE: begin
          if (cnt == 5'(POW_N - 1)) begin
            cnt   <= 5'(EXP_TERMS);
            state <= S_H_MUL;
          end else begin
            cnt   <= cnt + 5'd1;
            state <= S_EXP_MUL;
          end
        end
        S_H_MUL:    state <= S_H_RMUL;
        S_H_RMUL:   state <= S_H_FIX;
        S_H_FIX: begin
          if (cnt == 5'd1) begin
            state <= S_FIN_MUL;
          end else begin
            cnt   <= cnt - 5'd1;
            state <= S_H_MUL;
          end
        end
        S_FIN_MUL:  state <= S_FIN_ADD;
        S_FIN_ADD: begin
          if (side) begin
            state <= S_PSI_MUL;
          end else begin
            side  <= 1'b1;
            state <= S_DIFF;
          end
        end
        S_PSI_MUL:  state <= S_DN;
        S_DN:       state <= st.start ? S_COMMIT : S_ACC_MUL;
        S_ACC_MUL:  state <= S_COMMIT;
        S_COMMIT:   if (!st.out_busy) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/mdg_datapath.sv
// Datapath: shared multiplier, radix-2 divider, exponential and chain state.
module mdg_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  mdg_pkg::cmd_t                     cmd,
  output mdg_pkg::status_t                  st,
  input  logic signed [mdg_pkg::POS_W-1:0]  cfg_start,
  input  logic [mdg_pkg::DELTA_W-1:0]       cfg_delta,
  input  logic signed [mdg_pkg::POS_W-1:0]  cfg_mu,
  input  logic [mdg_pkg::DELTA_W-1:0]       cfg_sigma,
  input  logic                              start_req,
  input  logic [15:0]                       step_random,
  input  logic [15:0]                       accept_random,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mdg_pkg::POS_W-1:0]  sample,
  output logic                              accepted,
  output logic [mdg_pkg::REJ_W-1:0]         rejections
);
  import mdg_pkg::*;

  logic                     start_flag;
  logic [RAND_BITS-1:0]     u;
  logic [RAND_BITS-1:0]     r;
  logic signed [POS_W-1:0]  position;
  logic [DENS_W-1:0]        dens_cur;
  logic [REJ_W-1:0]         rej_cnt;
  logic signed [POS_W-1:0]  nx;
  logic [46:0]              den;
  logic [24:0]              dmag;
  logic [64:0]              rem;
  logic [66:0]              dsh;
  logic [QUOT_W-1:0]        qv;
  logic                     zero_flag;
  logic [30:0]              e;
  logic [30:0]              p;
  logic [30:0]              t;
  logic [17:0]              psi;
  logic [DENS_W-1:0]        dn;
  logic [63:0]              prod;

  logic [31:0]              mul_a;
  logic [31:0]              mul_b;
  logic                     mul_en;
  logic signed [25:0]       offset;
  logic signed [25:0]       nx_full;
  logic signed [25:0]       mu_sel;
  logic signed [25:0]       diff;
  logic [48:0]              d2;
  logic [29:0]              g;
  logic [31:0]              q0;
  logic [35:0]              qk;
  logic [30:0]              hrem;
  logic [31:0]              hd;
  logic                     take;

  assign st.zero     = zero_flag;
  assign st.start    = start_flag;
  assign st.out_busy = out_valid && !out_ready;

  assign d2 = prod[48:0];
  assign g  = {qv[FRAC_BITS-1:0], 14'b0};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    if (cmd.psi_mul) begin
      mul_a = {14'b0, psi};
      mul_b = {14'b0, psi};
    end else if (cmd.acc_mul) begin
      mul_a = {16'b0, r};
      mul_b = dens_cur[31:0];
    end else begin
      unique case (cmd.op)
        OP_PROP_MUL: begin
          mul_a = {9'b0, cfg_delta};
          mul_b = {16'b0, u};
        end
        OP_DEN_MUL: begin
          mul_a = {9'b0, cfg_sigma};
          mul_b = {9'b0, cfg_sigma};
        end
        OP_SQ_MUL: begin
          mul_a = {7'b0, dmag};
          mul_b = {7'b0, dmag};
        end
        OP_EXP_MUL: begin
          mul_a = {1'b0, e};
          mul_b = {1'b0, qv[FRAC_BITS + 32'(cmd.idx[2:0])] ? exp_pow(cmd.idx[2:0]) : Q30_ONE};
        end
        OP_H_MUL: begin
          mul_a = {2'b0, g};
          mul_b = {1'b0, p};
        end
        OP_H_RMUL: begin
          mul_a = {1'b0, prod[60:30]};
          mul_b = recip(cmd.idx);
        end
        OP_FIN_MUL: begin
          mul_a = {1'b0, e};
          mul_b = {1'b0, p};
        end
        default: mul_en = 1'b0;
      endcase
    end
  end

  always_comb begin
    offset  = $signed({2'b0, prod[38:15]}) - $signed({3'b0, cfg_delta});
    nx_full = 26'(position) + offset;
    mu_sel  = cmd.side ? -26'(cfg_mu) : 26'(cfg_mu);
    diff    = 26'(nx) - mu_sel;
    q0      = prod[63:32];
    qk      = q0 * {32'b0, cmd.idx};
    hrem    = t - qk[30:0];
    hd      = (hrem >= {27'b0, cmd.idx}) ? q0 + 32'd1 : q0;
    take    = start_flag || ({16'b0, prod[47:0]} <= {dn, 16'b0});
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod <= mul_a * mul_b;
    if (cmd.dn_take) dn <= prod[51:16];
    if (cmd.fin_add) psi <= psi + {1'b0, prod[60:44]};
    unique case (cmd.op)
      OP_LOAD: begin
        u          <= step_random[RAND_BITS-1:0];
        r          <= accept_random[RAND_BITS-1:0];
      end
      OP_PROP_ADD: begin
        if (start_flag) nx <= cfg_start;
        else if (nx_full < 26'(POS_MIN)) nx <= POS_MIN;
        else if (nx_full > 26'(POS_MAX)) nx <= POS_MAX;
        else nx <= nx_full[POS_W-1:0];
      end
      OP_DEN_SET: begin
        den <= {prod[45:0], 1'b0};
        psi <= '0;
      end
      OP_DIFF: dmag <= diff[25] ? 25'(-diff) : diff[24:0];
      OP_DIV_INIT: begin
        rem       <= {d2, 16'b0};
        dsh       <= {den, 20'b0};
        qv        <= '0;
        e         <= Q30_ONE;
        p         <= Q30_ONE;
      end
      OP_DIV_STEP: begin
        if ({2'b0, rem} >= dsh) begin
          rem <= rem - dsh[64:0];
          qv  <= {qv[QUOT_W-2:0], 1'b1};
        end else begin
          qv  <= {qv[QUOT_W-2:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      OP_EXP_TAKE: e <= prod[60:30];
      OP_H_RMUL:   t <= prod[60:30];
      OP_H_FIX:    p <= Q30_ONE - hd[30:0];
      default: ;
    endcase
    if (cmd.commit) begin
      sample   <= take ? nx : position;
      accepted <= take;
      if (start_flag) rejections <= '0;
      else if (!take && rej_cnt != REJ_MAX) rejections <= rej_cnt + 32'd1;
      else rejections <= rej_cnt;
    end
    if (rst) begin
      position   <= '0;
      dens_cur   <= '0;
      rej_cnt    <= '0;
      out_valid  <= 1'b0;
      start_flag <= 1'b0;
      zero_flag  <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD) start_flag <= start_req;
      if (cmd.op == OP_DIV_INIT) zero_flag <= ({3'b0, d2} >= {den, 5'b0});
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (take) begin
          position <= nx;
          dens_cur <= dn;
        end
        if (start_flag) rej_cnt <= '0;
        else if (!take && rej_cnt != REJ_MAX) rej_cnt <= rej_cnt + 32'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/metropolis_double_gaussian_sampler.sv
// Top level: register port, sequencer and datapath of the Metropolis sampler.
//
//   channel | direction | handshake         | word
//   in      | input     | in_valid/in_ready | start_req, step_random, accept_random
//   out     | output    | out_valid/out_ready | sample, accepted, rejections
//   cfg     | input     | APB psel/penable  | start_position .. peak_width
//
// A start word skips the acceptance multiply that a step word takes. A Gaussian term past
// the cutoff skips its divider, powers and series. The one shared 32x32 multiplier, the
// 21-step divider and the 12-term series serve both Gaussian terms in turn.
// A result waits in the output register; the next word is taken once it is loaded.
// A full output register holds the sequencer in its commit step.
// Reset clears the chain to position zero with zero density and count.
module metropolis_double_gaussian_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mdg_pkg::ADDR_W-1:0]          paddr,
  input  logic [mdg_pkg::DATA_W-1:0]          pwdata,
  output logic [mdg_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic [15:0]                         step_random,
  input  logic [15:0]                         accept_random,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mdg_pkg::POS_W-1:0]    sample,
  output logic                                accepted,
  output logic [mdg_pkg::REJ_W-1:0]           rejections
);
  import mdg_pkg::*;

  logic signed [POS_W-1:0] start_position;
  logic [DELTA_W-1:0]      step_half_width;
  logic signed [POS_W-1:0] peak_offset;
  logic [DELTA_W-1:0]      peak_width;
  logic [1:0]              reg_idx;
  cmd_t                    cmd;
  status_t                 st;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_position  <= '0;
      step_half_width <= 23'd65536;
      peak_offset     <= 24'sd65536;
      peak_width      <= 23'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_START: start_position  <= pwdata[POS_W-1:0];
        REG_DELTA: step_half_width <= pwdata[DELTA_W-1:0];
        REG_MU:    peak_offset     <= pwdata[POS_W-1:0];
        REG_SIGMA: peak_width      <= (pwdata[DELTA_W-1:0] == '0) ? 23'd1
                                                                 : pwdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START: prdata = {8'b0, start_position};
      REG_DELTA: prdata = {9'b0, step_half_width};
      REG_MU:    prdata = {8'b0, peak_offset};
      REG_SIGMA: prdata = {9'b0, peak_width};
      default:   prdata = '0;
    endcase
  end

  mdg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mdg_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_start     (start_position),
    .cfg_delta     (step_half_width),
    .cfg_mu        (peak_offset),
    .cfg_sigma     (peak_width),
    .start_req     (start_req),
    .step_random   (step_random),
    .accept_random (accept_random),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample        (sample),
    .accepted      (accepted),
    .rejections    (rejections)
  );

  a_reject_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> rejections != '0)
    else $error("rejected word with zero rejection count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded without returning to idle");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the double Gaussian Metropolis sampler.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mdg_pkg::*;

  typedef struct packed {
    logic        restart;
    logic [15:0] u_step;
    logic [15:0] u_accept;
  } walk_word_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             took;
    logic [REJ_W-1:0] rej;
  } chain_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic start_req = 1'b0;
  logic [15:0] step_random = '0, accept_random = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] sample;
  logic accepted;
  logic [REJ_W-1:0] rejections;

  always #2 clk = ~clk;

  metropolis_double_gaussian_sampler u_dut (.*);

  walk_word_t  walk_q[$];
  chain_word_t chain_q[$];
  int idle_pct = 0, stall_pct = 0;
  int mismatches = 0;
  longint cycles = 0;
  bit hold_sender = 1'b0;

  // model state
  longint m_start, m_mu;
  longint unsigned m_delta, m_sigma;
  longint m_pos;
  longint unsigned m_dens, m_rej;

  function automatic longint unsigned gauss_q(longint unsigned dmag, longint unsigned den);
    longint unsigned d2, q, rem, frac, g, p, e;
    longint unsigned pw[5];
    pw[0] = 395007542; pw[1] = 145315154; pw[2] = 19666267; pw[3] = 360200; pw[4] = 121;
    d2 = dmag * dmag;
    frac = 0;
    e = 64'd1 << 30;
    if (d2 >= den * 32) return 0;
    q = d2 / den;
    rem = d2 % den;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= den) begin
        rem -= den;
        frac |= 1;
      end
    end
    for (int i = 0; i < 5; i++)
      if (q[i]) e = (e * pw[i]) >> 30;
    g = frac << (30 - FRAC_BITS);
    p = 64'd1 << 30;
    for (int k = EXP_TERMS; k >= 1; k--)
      p = (64'd1 << 30) - ((g * p) >> 30) / k;
    e = (e * p) >> 30;
    return e >> (30 - FRAC_BITS);
  endfunction

  function automatic longint unsigned psi_squared(longint x);
    longint unsigned den, psi;
    den = 2 * m_sigma * m_sigma;
    psi = gauss_q((x >= m_mu) ? x - m_mu : m_mu - x, den) +
          gauss_q((x >= -m_mu) ? x + m_mu : -m_mu - x, den);
    return (psi * psi) >> FRAC_BITS;
  endfunction

  function automatic chain_word_t advance_chain(walk_word_t w);
    chain_word_t c;
    longint off, nx;
    longint unsigned dn;
    c.took = 1'b1;
    if (w.restart) begin
      m_pos = m_start;
      m_dens = psi_squared(m_pos);
      m_rej = 0;
    end else begin
      off = longint'((m_delta * w.u_step * 2) >> RAND_BITS) - longint'(m_delta);
      nx = m_pos + off;
      if (nx < -8388608) nx = -8388608;
      if (nx > 8388607) nx = 8388607;
      dn = psi_squared(nx);
      if (longint'(w.u_accept) * m_dens <= (dn << RAND_BITS)) begin
        m_pos = nx;
        m_dens = dn;
      end else begin
        c.took = 1'b0;
        if (m_rej < 64'hFFFF_FFFF) m_rej++;
      end
    end
    c.pos = m_pos[POS_W-1:0];
    c.rej = m_rej[REJ_W-1:0];
    return c;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4_000_000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (walk_q.size() > 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
        chain_q.push_back(advance_chain(walk_q[0]));
        {start_req, step_random, accept_random} <= walk_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    chain_word_t exp_w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (chain_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h %b %h", sample, accepted, rejections);
        end else begin
          exp_w = chain_q.pop_front();
          if (sample !== exp_w.pos || accepted !== exp_w.took || rejections !== exp_w.rej) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %b %h got %h %b %h", exp_w.pos, exp_w.took,
                       exp_w.rej, sample, accepted, rejections);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START: m_start = longint'($signed(val[23:0]));
      REG_DELTA: m_delta = 64'(val[22:0]);
      REG_MU:    m_mu = longint'($signed(val[23:0]));
      default: begin
        m_sigma = 64'(val[22:0]);
        if (m_sigma == 0) m_sigma = 1;
      end
    endcase
  endtask

  task automatic drain();
    while (walk_q.size() > 0 || in_valid || chain_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic push(bit s, logic [15:0] u, logic [15:0] r);
    walk_word_t w;
    w.restart = s; w.u_step = u; w.u_accept = r;
    walk_q.push_back(w);
  endtask

  task automatic random_chain(int n);
    push(1'b1, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++)
      push(($urandom_range(39) == 0), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    m_start = 0; m_delta = 65536; m_mu = 65536; m_sigma = 65536;
    m_pos = 0; m_dens = 0; m_rej = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: steps before start, then extremes
    push(1'b0, 16'hFFFF, 16'hFFFF);
    push(1'b0, 16'h0000, 16'h0000);
    push(1'b1, 16'h1234, 16'h5678);
    push(1'b0, 16'hFFFF, 16'hFFFF);
    push(1'b0, 16'h0000, 16'hFFFF);
    push(1'b0, 16'h8000, 16'h0000);
    push(1'b0, 16'hAAAA, 16'h5555);
    push(1'b0, 16'h5555, 16'hAAAA);
    drain();
    write_reg(REG_START, 32'h007F_FFFF);
    write_reg(REG_DELTA, 32'h007F_FFFF);
    write_reg(REG_MU, 32'h0080_0000);
    write_reg(REG_SIGMA, 32'h0000_0000);
    push(1'b1, 16'h0000, 16'h0000);
    push(1'b0, 16'hFFFF, 16'hFFFF);
    push(1'b0, 16'h0000, 16'hFFFF);
    push(1'b0, 16'h0000, 16'h0000);
    push(1'b0, 16'hFFFF, 16'h0000);
    drain();
    write_reg(REG_START, 32'h0080_0000);
    write_reg(REG_SIGMA, 32'h007F_FFFF);
    write_reg(REG_MU, 32'h007F_FFFF);
    write_reg(REG_DELTA, 32'h0000_0000);
    push(1'b1, 16'h0000, 16'h0000);
    push(1'b0, 16'hFFFF, 16'hFFFF);
    push(1'b0, 16'h1234, 16'hFFFF);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      write_reg(REG_START, $urandom_range(32'h3FFFF) - 32'h20000);
      write_reg(REG_DELTA, (ph == 7) ? 32'h7F_FFFF : $urandom_range(32'h30000, 32'h100));
      write_reg(REG_MU, $urandom_range(32'h40000) - 32'h20000);
      write_reg(REG_SIGMA, (ph == 6) ? 32'd1 : $urandom_range(32'h30000, 32'h4000));
      if (ph == 3) begin
        random_chain(104);
        while (walk_q.size() > 50) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || chain_q.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
        random_chain(104);
      end else begin
        random_chain(210);
      end
      drain();
    end

    if (mismatches == 0 && chain_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// File: metropolis_double_gaussian_sampler.f
hw/rtl/mdg_pkg.sv
hw/rtl/mdg_ctrl.sv
hw/rtl/mdg_datapath.sv
hw/rtl/metropolis_double_gaussian_sampler.sv
tb/tb_top.sv
